>>> rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// shared types and codes for the indexed lifo stack
// ----------------------------------------------------------------------------
package ils_pkg;

  // request codes
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // the action that every cell takes
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } cell_act_t;

  // register map
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned REG_DEPTH_LIMIT = 0;
  localparam int unsigned LIMIT_W         = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FIELD_W = 7;

endpackage

>>> rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// one stack slot; cell 0 holds the top entry, deeper cells hold older ones
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int unsigned ENTRY_WIDTH = 32,
  parameter int unsigned CW          = 7,
  parameter int unsigned IDX         = 0
) (
  input  logic                   clk,
  input  ils_pkg::cell_act_t     act,
  input  logic [CW-1:0]          split,
  input  logic [ENTRY_WIDTH-1:0] load_data,
  input  logic [ENTRY_WIDTH-1:0] from_shallow,
  input  logic [ENTRY_WIDTH-1:0] from_deep,
  output logic [ENTRY_WIDTH-1:0] value
);
  import ils_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [ENTRY_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    case (act)
      ACT_INSERT: begin
        // cells past the split move one deeper, the split cell takes the new entry
        if (MY_IDX > split) begin
          value_next = from_shallow;
        end else if (MY_IDX == split) begin
          value_next = load_data;
        end
      end
      ACT_DELETE: begin
        // cells from the split on close the gap
        if (MY_IDX >= split) begin
          value_next = from_deep;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> rtl/indexed_lifo_stack_top.sv
// ----------------------------------------------------------------------------
// indexed_lifo_stack_top
// bounded lifo stack with push, pop, peek, indexed insert, indexed delete
// and clear, built as a chain of register cells
// ----------------------------------------------------------------------------
// The stack holds up to MAX_DEPTH entries in a row of cells, the top entry
// always in cell 0, so pop and peek read one fixed cell and every insert or
// delete is a single parallel shift of the cells on one side of a split
// point. One transaction is taken per clock cycle and its result appears in
// the output register on the next cycle; the state one request leaves for
// the next, the fill count register and the cells, is updated in that same
// cycle. The input stalls only while a result sits in the output register
// and the output side is stalling. On full, empty or index out of range the
// contents and fill count are left unchanged. Register depth_limit (byte
// address 0, reset 64) caps the entries in use; values above MAX_DEPTH act
// as MAX_DEPTH, and lowering it below the fill count keeps the entries
// above the limit. No clearing pass is needed after reset.
module indexed_lifo_stack_top #(
  parameter int unsigned MAX_DEPTH   = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        op,
  input  logic [ils_pkg::DATA_W-1:0]        data_in,
  input  logic [ils_pkg::FIELD_W-1:0]       position,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [ils_pkg::DATA_W-1:0]        data_out,
  output logic [ils_pkg::FIELD_W-1:0]       fill_count,
  output logic [ils_pkg::FIELD_W-1:0]       free_slots,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ils_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ils_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ils_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ils_pkg::*;

  // count width holds 0..MAX_DEPTH; compare width also covers the 7-bit fields
  localparam int unsigned CW   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CMPW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(MAX_DEPTH);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] depth_limit;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_DEPTH_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      depth_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // only one register, so every read address returns it
  assign prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, depth_limit};

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  logic accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // request decode and checks
  // --------------------------------------------------------------------------
  logic [CW-1:0]          top_count;
  logic [CW-1:0]          top_count_next;
  logic [CMPW-1:0]        tc_x;
  logic [CMPW-1:0]        pos_x;
  logic [CMPW-1:0]        lim_x;
  logic [CMPW-1:0]        lim_raw;
  logic [CMPW-1:0]        fill_x;
  logic [CMPW-1:0]        free_x;
  status_t                st;
  logic                   rd_top;
  cell_act_t              act;
  logic [CW-1:0]          split;
  op_t                    op_c;

  assign op_c    = op_t'(op);
  assign tc_x    = CMPW'(top_count);
  assign pos_x   = CMPW'(position);
  assign lim_raw = CMPW'(depth_limit);
  assign lim_x   = (lim_raw > DEPTH_C) ? DEPTH_C : lim_raw;

  always_comb begin
    st             = ST_OK;
    rd_top         = 1'b0;
    act            = ACT_HOLD;
    split          = '0;
    top_count_next = top_count;
    case (op_c)
      OP_PUSH: begin
        if (tc_x >= lim_x) begin
          st = ST_FULL;
        end else begin
          // push is an insert just above the top: split at cell 0
          act            = ACT_INSERT;
          top_count_next = top_count + 1'b1;
        end
      end
      OP_POP: begin
        if (top_count == '0) begin
          st = ST_EMPTY;
        end else begin
          rd_top         = 1'b1;
          act            = ACT_DELETE;
          top_count_next = top_count - 1'b1;
        end
      end
      OP_PEEK: begin
        if (top_count == '0) begin
          st = ST_EMPTY;
        end else begin
          rd_top = 1'b1;
        end
      end
      OP_INSERT: begin
        if (tc_x >= lim_x) begin
          st = ST_FULL;
        end else if (pos_x > tc_x) begin
          st = ST_RANGE;
        end else begin
          // bottom index pos sits at cell top_count - pos after the insert
          act            = ACT_INSERT;
          split          = CW'(tc_x - pos_x);
          top_count_next = top_count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_x >= tc_x) begin
          st = ST_RANGE;
        end else begin
          // bottom index pos lives in cell top_count - 1 - pos
          act            = ACT_DELETE;
          split          = CW'(tc_x - pos_x - 1'b1);
          top_count_next = top_count - 1'b1;
        end
      end
      OP_CLEAR: begin
        top_count_next = '0;
      end
      default: begin
        // unused codes change nothing and report ok
        st = ST_OK;
      end
    endcase
  end

  assign fill_x = CMPW'(top_count_next);
  assign free_x = (fill_x >= lim_x) ? '0 : (lim_x - fill_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= '0;
    end else if (accept) begin
      top_count <= top_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // cell chain
  // --------------------------------------------------------------------------
  logic [ENTRY_WIDTH-1:0]        cell_val [MAX_DEPTH];
  logic [ENTRY_WIDTH+DATA_W-1:0] data_ext;
  logic [ENTRY_WIDTH-1:0]        load_data;
  cell_act_t                     cell_act;

  assign data_ext  = {{ENTRY_WIDTH{1'b0}}, data_in};
  assign load_data = data_ext[ENTRY_WIDTH-1:0];
  assign cell_act  = accept ? act : ACT_HOLD;

  for (genvar j = 0; j < MAX_DEPTH; j++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] shallow;
    logic [ENTRY_WIDTH-1:0] deep;

    if (j == 0) begin : g_first
      assign shallow = '0;
    end else begin : g_mid_shallow
      assign shallow = cell_val[j-1];
    end

    if (j == MAX_DEPTH - 1) begin : g_last
      assign deep = '0;
    end else begin : g_mid_deep
      assign deep = cell_val[j+1];
    end

    ils_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .CW          (CW),
      .IDX         (j)
    ) u_cell (
      .clk          (clk),
      .act          (cell_act),
      .split        (split),
      .load_data    (load_data),
      .from_shallow (shallow),
      .from_deep    (deep),
      .value        (cell_val[j])
    );
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic [ENTRY_WIDTH+DATA_W-1:0] top_ext;

  assign top_ext = {{DATA_W{1'b0}}, cell_val[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= st;
      data_out   <= rd_top ? top_ext[DATA_W-1:0] : '0;
      fill_count <= fill_x[FIELD_W-1:0];
      free_slots <= free_x[FIELD_W-1:0];
    end
  end

endmodule
